/* rtl/four_state_vector_alu_assert.svh */
// ----------------------------------------------------------------------------
// four_state_vector_alu_assert.svh
// assertion macros shared by the four-state vector alu rtl
// ----------------------------------------------------------------------------
`ifndef FOUR_STATE_VECTOR_ALU_ASSERT_SVH
`define FOUR_STATE_VECTOR_ALU_ASSERT_SVH
`ifndef SYNTHESIS
// checked on every clock edge out of reset
`define FSVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every clock edge, reset included
`define FSVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSVA_ASSERT(lbl, prop, msg)
`define FSVA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/fsva_pkg.sv */
// ----------------------------------------------------------------------------
// fsva_pkg
// types, codes and helpers for the four-state vector alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsva_pkg;

  localparam int DATA_W  = 64;
  localparam int WIDTH_W = 7;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH_IN_USE = 1'b0;

  typedef enum logic [2:0] {
    FN_LOAD = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_INC  = 3'd3,
    FN_DEC  = 3'd4,
    FN_ROR  = 3'd5,
    FN_ROL  = 3'd6,
    FN_NOP  = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ABORT    = 2'd2
  } status_t;

  typedef struct packed {
    logic              integer_mode;
    func_t             func;
    logic [DATA_W-1:0] operand_dont_care;
    logic [DATA_W-1:0] operand_unknown;
    logic [DATA_W-1:0] operand_value;
  } item_t;

  // per position code: hi,lo = 00 zero, 01 one, 10 unknown, 11 don't-care
  typedef struct packed {
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
  } acc_t;

  typedef struct packed {
    acc_t    acc;
    status_t status;
  } core_out_t;

  function automatic logic [DATA_W-1:0] make_mask(input logic [WIDTH_W-1:0] n);
    logic [DATA_W-1:0] m;
    if (n >= WIDTH_W'(DATA_W)) begin
      m = '1;
    end else begin
      m = (DATA_W'(1) << n) - DATA_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/fsva_core.sv */
// ----------------------------------------------------------------------------
// fsva_core
// single pass datapath: next accumulator and status for one operation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsva_core (
  input  fsva_pkg::acc_t               acc_cur,
  input  fsva_pkg::item_t              item,
  input  logic [fsva_pkg::WIDTH_W-1:0] n,
  output fsva_pkg::core_out_t          res
);
  import fsva_pkg::*;

  logic [DATA_W-1:0] m;
  logic [DATA_W-1:0] top_m;
  logic [DATA_W-1:0] a_val;
  logic [DATA_W-1:0] b_val;
  logic [DATA_W:0]   sum_ext;
  logic [DATA_W-1:0] cin;
  logic [DATA_W-1:0] zero_from;
  logic [DATA_W-1:0] stop_a;
  logic [DATA_W-1:0] ev_a;
  logic [DATA_W-1:0] first_a;
  logic              carry_out;
  logic [DATA_W-1:0] stop_c;
  logic [DATA_W-1:0] ev_c;
  logic [DATA_W-1:0] first_c;
  logic [DATA_W-1:0] x_lo;
  logic [DATA_W-1:0] x_hi;
  logic [DATA_W-1:0] rr_lo;
  logic [DATA_W-1:0] rr_hi;
  logic [DATA_W-1:0] rl_lo;
  logic [DATA_W-1:0] rl_hi;
  logic [DATA_W-1:0] ld_lo;
  logic [DATA_W-1:0] ld_hi;
  logic [DATA_W-1:0] wm;

  assign m     = make_mask(n);
  assign top_m = m & ~(m >> 1);
  assign a_val = acc_cur.lo & ~acc_cur.hi & m;
  assign b_val = item.operand_value & m;

  // add / subtract, carry or borrow out of the top active position at bit n
  assign sum_ext   = (item.func == FN_SUB) ? ({1'b0, a_val} - {1'b0, b_val})
                                           : ({1'b0, a_val} + {1'b0, b_val});
  assign cin       = sum_ext[DATA_W-1:0] ^ a_val ^ b_val;
  assign carry_out = sum_ext[n];

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      zero_from[i] = ~|(item.operand_value >> i);
    end
  end

  // integer mode stops where the rest of the operand and the carry are zero
  assign stop_a  = item.integer_mode ? (zero_from & ~cin) : '0;
  assign ev_a    = (stop_a | acc_cur.hi | (item.integer_mode ? '0 : item.operand_unknown)) & m;
  assign first_a = ev_a & (~ev_a + DATA_W'(1));

  // count stops at the first position that absorbs the carry or borrow
  assign stop_c  = ((item.func == FN_DEC) ? acc_cur.lo : ~acc_cur.lo) & ~acc_cur.hi;
  assign ev_c    = (stop_c | acc_cur.hi) & m;
  assign first_c = ev_c & (~ev_c + DATA_W'(1));

  assign x_lo  = acc_cur.lo & m;
  assign x_hi  = acc_cur.hi & m;
  assign rr_lo = (x_lo >> 1) | (x_lo[0] ? top_m : '0);
  assign rr_hi = (x_hi >> 1) | (x_hi[0] ? top_m : '0);
  assign rl_lo = ((x_lo << 1) & m) | DATA_W'(|(x_lo & top_m));
  assign rl_hi = ((x_hi << 1) & m) | DATA_W'(|(x_hi & top_m));

  // don't-care wins over unknown
  assign ld_hi = item.operand_dont_care | item.operand_unknown;
  assign ld_lo = item.operand_dont_care | (~item.operand_unknown & item.operand_value);

  always_comb begin
    res.acc    = acc_cur;
    res.status = ST_OK;
    wm         = '0;
    unique case (item.func)
      FN_LOAD: begin
        res.acc.hi = (acc_cur.hi & ~m) | (ld_hi & m);
        res.acc.lo = (acc_cur.lo & ~m) | (ld_lo & m);
      end
      FN_ADD, FN_SUB: begin
        if (ev_a == '0) begin
          wm         = m;
          res.status = carry_out ? ST_OVERFLOW : ST_OK;
        end else begin
          wm         = first_a - DATA_W'(1);
          res.status = ((first_a & stop_a) != '0) ? ST_OK : ST_ABORT;
        end
        res.acc.lo = (acc_cur.lo & ~wm) | (sum_ext[DATA_W-1:0] & wm);
        res.acc.hi = acc_cur.hi & ~wm;
      end
      FN_INC, FN_DEC: begin
        if (ev_c == '0) begin
          wm         = m;
          res.status = ST_OVERFLOW;
        end else if ((first_c & stop_c) != '0) begin
          wm         = first_c | (first_c - DATA_W'(1));
          res.status = ST_OK;
        end else begin
          wm         = first_c - DATA_W'(1);
          res.status = ST_ABORT;
        end
        res.acc.lo = acc_cur.lo ^ wm;
      end
      FN_ROR: begin
        res.acc.lo = (acc_cur.lo & ~m) | rr_lo;
        res.acc.hi = (acc_cur.hi & ~m) | rr_hi;
      end
      FN_ROL: begin
        res.acc.lo = (acc_cur.lo & ~m) | rl_lo;
        res.acc.hi = (acc_cur.hi & ~m) | rl_hi;
      end
      FN_NOP: begin
        res.acc = acc_cur;
      end
      default: begin
        res.acc = acc_cur;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/four_state_vector_alu.sv */
// ----------------------------------------------------------------------------
// four_state_vector_alu
// accumulator alu over a vector of zero / one / unknown / don't-care positions
// ----------------------------------------------------------------------------
// path: an operation passes the input register, then the result register, and
//   m_tvalid rises once the result register is loaded
// throughput: one operation per clock while m_tready drains the result register;
//   the accumulator update (one 64-bit carry chain plus the abort prefix) is combinational
// reset (synchronous, rst high): accumulator all zero, width_in_use = 64,
//   input and result registers empty
`timescale 1ns / 1ps
`default_nettype none

`include "four_state_vector_alu_assert.svh"

module four_state_vector_alu #(
  parameter int MAX_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // operand_value, operand_unknown, operand_dont_care
  input  logic [3*fsva_pkg::DATA_W-1:0] s_tdata,
  // func, integer_mode
  input  logic [3:0]                    s_tuser,
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // value_bits, unknown_bits, dont_care_bits
  output logic [3*fsva_pkg::DATA_W-1:0] m_tdata,
  // status
  output logic [1:0]                    m_tuser,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fsva_pkg::*;

  logic [WIDTH_W-1:0]  width_in_use;
  logic [WIDTH_W-1:0]  n;
  logic [MAX_BITS-1:0] acc_lo;
  logic [MAX_BITS-1:0] acc_hi;
  logic [DATA_W-1:0]   m_full;
  logic                in_full;
  item_t               in_item;
  logic                fire;
  acc_t                acc_ext;
  core_out_t           core_res;
  logic [DATA_W-1:0]   res_val;
  logic [DATA_W-1:0]   res_unk;
  logic [DATA_W-1:0]   res_dc;
  logic [DATA_W-1:0]   res_overlap;
  logic [DATA_W-1:0]   idle_change;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WIDTH_IN_USE) ? {25'b0, width_in_use} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use <= WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WIDTH_IN_USE) begin
      width_in_use <= pwdata[WIDTH_W-1:0];
    end
  end

  assign n        = (width_in_use > WIDTH_W'(MAX_BITS)) ? WIDTH_W'(MAX_BITS) : width_in_use;
  assign m_full   = make_mask(n);

  // result register is free or being drained this cycle
  assign fire     = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.operand_value     <= s_tdata[DATA_W-1:0];
      in_item.operand_unknown   <= s_tdata[2*DATA_W-1:DATA_W];
      in_item.operand_dont_care <= s_tdata[3*DATA_W-1:2*DATA_W];
      in_item.func              <= func_t'(s_tuser[2:0]);
      in_item.integer_mode      <= s_tuser[3];
    end
  end

  assign acc_ext.lo = DATA_W'(acc_lo);
  assign acc_ext.hi = DATA_W'(acc_hi);

  fsva_core u_core (
    .acc_cur (acc_ext),
    .item    (in_item),
    .n       (n),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_lo <= '0;
      acc_hi <= '0;
    end else if (fire) begin
      acc_lo <= core_res.acc.lo[MAX_BITS-1:0];
      acc_hi <= core_res.acc.hi[MAX_BITS-1:0];
    end
  end

  assign res_val = core_res.acc.lo & ~core_res.acc.hi & m_full;
  assign res_unk = ~core_res.acc.lo & core_res.acc.hi & m_full;
  assign res_dc  = core_res.acc.lo & core_res.acc.hi & m_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {res_dc, res_unk, res_val};
      m_tuser <= core_res.status;
    end
  end

  assign res_overlap = (m_tdata[DATA_W-1:0] & m_tdata[2*DATA_W-1:DATA_W])
                     | (m_tdata[DATA_W-1:0] & m_tdata[3*DATA_W-1:2*DATA_W])
                     | (m_tdata[2*DATA_W-1:DATA_W] & m_tdata[3*DATA_W-1:2*DATA_W]);
  assign idle_change = ((core_res.acc.lo ^ acc_ext.lo) | (core_res.acc.hi ^ acc_ext.hi))
                     & ~m_full;

  `FSVA_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid && !in_full, "registers not empty after reset")
  `FSVA_ASSERT(a_codes_exclusive, m_tvalid |-> res_overlap == '0, "result masks overlap")
  `FSVA_ASSERT(a_load_ok, fire && in_item.func == FN_LOAD |=> m_tuser == ST_OK, "load gave status")
  `FSVA_ASSERT(a_inactive_kept, fire |-> idle_change == '0, "inactive position changed")
  `FSVA_ASSERT(a_hold_input, in_full && !fire |-> !s_tready, "input taken while item waits")

endmodule

`default_nettype wire
